@@ rtl/core/iaidf_pkg.sv @@
// Shared constants, codes and types for the indexed array insert/delete/find block.
package iaidf_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;

  // priority search groups
  localparam int GRP    = 8;
  localparam int SUB_W  = $clog2(GRP);
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_FIND   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GRP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;     // take the operand value
    logic take_lo;  // take the lower neighbor's entry (insert shift)
    logic take_hi;  // take the upper neighbor's entry (delete shift)
  } cell_ctl_t;

endpackage

@@ rtl/core/iaidf_cell.sv @@
// One storage cell of the shift array: holds an entry, shifts, compares.
module iaidf_cell (
  input  logic                            clk,
  input  iaidf_pkg::cell_ctl_t            ctl,
  input  logic signed [iaidf_pkg::DATA_W-1:0] op_val,
  input  logic signed [iaidf_pkg::DATA_W-1:0] lo_entry,
  input  logic signed [iaidf_pkg::DATA_W-1:0] hi_entry,
  output logic signed [iaidf_pkg::DATA_W-1:0] entry,
  output logic                            match
);
  import iaidf_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = op_val;
    end else if (ctl.take_lo) begin
      entry_nxt = lo_entry;
    end else if (ctl.take_hi) begin
      entry_nxt = hi_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == op_val);

endmodule

@@ rtl/core/iaidf_find.sv @@
// Two-stage registered priority search for the lowest matching cell.
module iaidf_find (
  input  logic                        clk,
  input  logic [iaidf_pkg::DEPTH-1:0] match_i,
  output logic                        hit,
  output logic [iaidf_pkg::IDX_W-1:0] hit_idx
);
  import iaidf_pkg::*;

  logic [NGRP*GRP-1:0] match_r;
  logic [NGRP*GRP-1:0] match_nxt;
  logic [NGRP-1:0]     grp_any_r;
  logic [NGRP-1:0]     grp_any_nxt;
  logic [SUB_W-1:0]    grp_sub_r   [NGRP];
  logic [SUB_W-1:0]    grp_sub_nxt [NGRP];

  always_comb begin
    match_nxt = '0;
    match_nxt[DEPTH-1:0] = match_i;
  end

  // stage 1: lowest hit inside each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_sub_nxt[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (match_r[g*GRP + j]) begin
          grp_any_nxt[g] = 1'b1;
          grp_sub_nxt[g] = SUB_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    match_r   <= match_nxt;
    grp_any_r <= grp_any_nxt;
    grp_sub_r <= grp_sub_nxt;
  end

  // stage 2: lowest group with a hit
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(g*GRP + int'(grp_sub_r[g]));
      end
    end
  end

endmodule

@@ rtl/core/indexed_array_insert_delete_find.sv @@
// Top level: packed shift array with insert, delete and find operations.
//
// Usage: present in_func/in_position/in_value with start while busy is low;
// the transaction is taken at that clock edge. Exactly one result follows,
// shown for a single cycle with out_valid high; the receiver cannot stall it,
// so it must capture the result in that cycle. Insert and delete run the
// execute state, in which the cells at and above the position shift or load
// in parallel, then show the registered result. In find the execute state
// captures one match bit per cell, then a two-stage registered priority
// search over groups of eight cells picks the lowest hit. busy drops in the
// same cycle out_valid rises, so a new transaction may be started there.
// Every result carries the entry count after the operation. A full table
// rejects insert with status 1; a bad position, an empty table on delete or
// an unused func code give status 2 and leave the table untouched. Entries
// come up undefined; only positions below the count are ever read. Reset
// (rst_n low, synchronous) empties the table.
module indexed_array_insert_delete_find (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [iaidf_pkg::FUNC_W-1:0]      in_func,
  input  logic [iaidf_pkg::POS_W-1:0]       in_position,
  input  logic signed [iaidf_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic [iaidf_pkg::IDX_W-1:0]       out_found_index,
  output logic                              out_found,
  output logic [iaidf_pkg::POS_W-1:0]       out_count,
  output logic [1:0]                        out_status
);
  import iaidf_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // latched transaction
  logic [FUNC_W-1:0]        op_func_r;
  logic [POS_W-1:0]         op_pos_r;
  logic signed [DATA_W-1:0] op_val_r;

  // result payload
  logic [IDX_W-1:0]  out_found_index_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_count_r;
  status_t           out_status_r;

  // sequencer outputs
  logic accept;
  logic exec_en;
  logic fin_en;

  // execute-cycle decode
  logic    ins_ok;
  logic    del_ok;
  status_t exec_status;

  // cell row
  cell_ctl_t                cell_ctl   [DEPTH];
  logic signed [DATA_W-1:0] cell_entry [DEPTH];
  logic [DEPTH-1:0]         cell_match;
  logic [DEPTH-1:0]         live_match;

  logic             srch_hit;
  logic [IDX_W-1:0] srch_idx;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // find continues into the search pipeline
        if (op_func_r == FN_FIND) begin
          state_nxt = S_GRP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GRP:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    exec_en = 1'b0;
    fin_en  = 1'b0;
    case (state_r)
      S_IDLE:  busy    = 1'b0;
      S_EXEC:  exec_en = 1'b1;
      S_GRP:   ;
      S_FIN:   fin_en  = 1'b1;
      default: busy    = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Operation decode (valid in the execute cycle)
  // ---------------------------------------------------------------------
  assign ins_ok = (op_func_r == FN_INSERT) && (count_r < POS_W'(DEPTH)) &&
                  (op_pos_r <= count_r);
  assign del_ok = (op_func_r == FN_DELETE) && (count_r != '0) &&
                  (op_pos_r < count_r);

  always_comb begin
    case (op_func_r)
      FN_INSERT: begin
        if (count_r >= POS_W'(DEPTH)) begin
          exec_status = ST_FULL;
        end else if (op_pos_r > count_r) begin
          exec_status = ST_RANGE;
        end else begin
          exec_status = ST_OK;
        end
      end
      FN_DELETE: exec_status = del_ok ? ST_OK : ST_RANGE;
      FN_FIND:   exec_status = ST_OK;
      default:   exec_status = ST_RANGE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (exec_en && ins_ok) begin
      count_nxt = count_r + POS_W'(1);
    end else if (exec_en && del_ok) begin
      count_nxt = count_r - POS_W'(1);
    end
  end

  // result strobe: non-find ops finish in execute, find in the final stage
  assign out_valid_nxt = (exec_en && (op_func_r != FN_FIND)) || fin_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r <= in_func;
      op_pos_r  <= in_position;
      op_val_r  <= in_value;
    end
    if (exec_en && (op_func_r != FN_FIND)) begin
      out_found_index_r <= '0;
      out_found_r       <= 1'b0;
      out_count_r       <= count_nxt;
      out_status_r      <= exec_status;
    end else if (fin_en) begin
      out_found_index_r <= srch_hit ? srch_idx : '0;
      out_found_r       <= srch_hit;
      out_count_r       <= count_r;
      out_status_r      <= ST_OK;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: each cell sees the broadcast operand and its two neighbors.
  // Insert: the cell at the position loads, cells above take from below.
  // Delete: cells at and above the position take from above.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_in;
    logic signed [DATA_W-1:0] hi_in;

    if (i == 0) begin : g_lo_edge
      assign lo_in = cell_entry[i];
    end else begin : g_lo_mid
      assign lo_in = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_in = cell_entry[i];
    end else begin : g_hi_mid
      assign hi_in = cell_entry[i+1];
    end

    assign cell_ctl[i].load    = exec_en && ins_ok && (op_pos_r == POS_W'(i));
    assign cell_ctl[i].take_lo = exec_en && ins_ok && (POS_W'(i) > op_pos_r);
    assign cell_ctl[i].take_hi = exec_en && del_ok && (POS_W'(i) >= op_pos_r);

    iaidf_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .op_val   (op_val_r),
      .lo_entry (lo_in),
      .hi_entry (hi_in),
      .entry    (cell_entry[i]),
      .match    (cell_match[i])
    );

    // only occupied cells may report a hit
    assign live_match[i] = cell_match[i] && (POS_W'(i) < count_r);
  end

  iaidf_find u_find (
    .clk     (clk),
    .match_i (live_match),
    .hit     (srch_hit),
    .hit_idx (srch_idx)
  );

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_index_r;
  assign out_found       = out_found_r;
  assign out_count       = out_count_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= POS_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_count_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_EXEC))
    else $error("count changed outside execute cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($past(state_r) == S_EXEC) || ($past(state_r) == S_FIN)))
    else $error("result strobe without execute or final stage");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |->
      ((POS_W'(out_found_index_r) < out_count_r) && (out_status_r == ST_OK)))
    else $error("found index beyond count");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("block still busy while result is shown");
`endif

endmodule
